// File: hdl/fir_convolution_envelope_assert.svh
// Assertion macros for the checker file of the FIR convolution block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef FIR_CONVOLUTION_ENVELOPE_ASSERT_SVH
`define FIR_CONVOLUTION_ENVELOPE_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define FCE_ASSERT_IMPLY(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define FCE_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// Shared widths, codes and types of the FIR convolution envelope block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fce_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int IDX_W      = 5;
  localparam int TAPCFG_W   = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Result queue; it covers the pipeline latency for every supported tap count.
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS   = CFG_IDX_W'(1);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Tag that travels alongside the sum pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    sample_t filtered;
    logic    clipped;
    logic    last_output;
  } rsp_t;

endpackage

`default_nettype wire

// File: hdl/fir_convolution_envelope.sv
// ----------------------------------------------------------------------------
// fir_convolution_envelope
// Full linear convolution of a sample stream with a loaded FIR kernel.
// ----------------------------------------------------------------------------
// Usage:
// Request items arrive on req_valid/req_stall. An item with req_type low loads
// one coefficient (coef_index, coef_value) and gives no result. An item with
// req_type high carries one sample and gives one result. A sample with
// last_sample set is followed by eff_taps - 1 tail results, computed with
// zeros shifted in; req_stall stays high for those tail cycles, and the delay
// line is cleared after the final tail result, which carries last_output.
// Result items leave on rsp_valid/rsp_stall through a 16-entry queue.
// Configuration writes use cfg_valid/cfg_ready, which is always ready.
// An accepted sample passes through the registered cell products, the
// registered adder tree levels and rounding into the result queue before its
// result reaches the result channel. Throughput is one item per cycle while
// req_stall is low. When the receiver stalls, results pile up in the queue;
// req_stall also rises once every queue slot is spoken for by a result in
// flight or waiting. Reset clears the delay line, the coefficients, the queue
// and the registers (envelope_mode 0, active_taps 31).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fir_convolution_envelope #(
  parameter int TAPS = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            req_type,
  input  logic [fce_pkg::IDX_W-1:0]       coef_index,
  input  logic signed [fce_pkg::COEF_W-1:0]   coef_value,
  input  logic signed [fce_pkg::SAMPLE_W-1:0] sample,
  input  logic                            last_sample,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic signed [fce_pkg::SAMPLE_W-1:0] filtered,
  output logic                            clipped,
  output logic                            last_output,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fce_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fce_pkg::*;

  localparam int LV = $clog2(TAPS);
  localparam int SW = PROD_W + LV;
  localparam int YW = SW + 1 - 16;
  localparam int TW = $clog2(TAPS + 1);
  // Tap counts are compared at the wider of the register width and the
  // width that holds TAPS.
  localparam int EW = (TW > TAPCFG_W) ? TW : TAPCFG_W;

  // Configuration registers.
  logic                envelope_mode;
  logic [TAPCFG_W-1:0] active_taps;
  logic [EW-1:0]       eff_taps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope_mode <= 1'b0;
      active_taps   <= TAPCFG_W'(31);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENVELOPE_MODE: envelope_mode <= cfg_data[0];
        REG_ACTIVE_TAPS:   active_taps   <= cfg_data[TAPCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // A tap count of zero acts as one, and a count above TAPS acts as TAPS.
  always_comb begin
    eff_taps = EW'(active_taps);
    if (eff_taps == '0) begin
      eff_taps = EW'(1);
    end else if (eff_taps > EW'(TAPS)) begin
      eff_taps = EW'(TAPS);
    end
  end

  // Request side. A sample or a tail step is an event that shifts the chain
  // and reserves one slot of the result queue.
  logic [CREDIT_W-1:0] credits;
  logic                credit_full;
  logic [EW-1:0]       tail_left;
  logic                flush_busy;
  logic                req_acc;
  logic                ev_sample;
  logic                ev_tail;
  logic                ev;
  logic                ev_last;
  logic                load_acc;
  logic                rsp_acc;
  sample_t             rect;
  sample_t             new_value;

  assign credit_full = (credits == CREDIT_W'(FIFO_DEPTH));
  assign flush_busy  = (tail_left != '0);
  assign req_stall   = flush_busy || credit_full;
  assign req_acc     = req_valid && !req_stall;
  assign ev_sample   = req_acc && (req_type == REQ_SAMPLE);
  assign load_acc    = req_acc && (req_type == REQ_LOAD);
  assign ev_tail     = flush_busy && !credit_full;
  assign ev          = ev_sample || ev_tail;
  assign ev_last     = (ev_sample && last_sample && (eff_taps == EW'(1))) ||
                       (ev_tail && (tail_left == EW'(1)));
  assign rsp_acc     = rsp_valid && !rsp_stall;

  // Rectification saturates the most negative sample to the largest positive.
  always_comb begin
    rect = sample;
    if (envelope_mode && sample[SAMPLE_W-1]) begin
      if (sample == {1'b1, {(SAMPLE_W - 1){1'b0}}}) begin
        rect = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      end else begin
        rect = -sample;
      end
    end
  end

  assign new_value = ev_tail ? '0 : rect;

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_left <= '0;
      credits   <= '0;
    end else begin
      if (ev_sample && last_sample && (eff_taps != EW'(1))) begin
        tail_left <= eff_taps - EW'(1);
      end else if (ev_tail) begin
        tail_left <= tail_left - EW'(1);
      end
      credits <= credits + CREDIT_W'(ev) - CREDIT_W'(rsp_acc);
    end
  end

  // Chain of tap cells; each hands its sample to the next on every event.
  cell_ctl_t ctl;
  sample_t   taps_q [TAPS];
  prod_t     prods  [TAPS];

  assign ctl.shift = ev;
  assign ctl.clear = ev_last;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    sample_t tap_in;
    logic    coef_we;
    logic    active;

    if (k == 0) begin : g_head
      assign tap_in = new_value;
    end else begin : g_link
      assign tap_in = taps_q[k - 1];
    end

    assign coef_we = load_acc && (int'(coef_index) == k);
    assign active  = (EW'(k) < eff_taps);

    fce_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .tap_in  (tap_in),
      .coef_we (coef_we),
      .coef_in (coef_value),
      .active  (active),
      .tap     (taps_q[k]),
      .prod    (prods[k])
    );
  end

  // Sum of the products, one register level per tree level.
  logic signed [SW-1:0] acc;

  fce_adder_tree #(
    .N  (TAPS),
    .SW (SW)
  ) u_tree (
    .clk  (clk),
    .prod (prods),
    .sum  (acc)
  );

  // Tags follow the products through the tree.
  tag_t tag_pipe [LV + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LV; i++) begin
        tag_pipe[i] <= '0;
      end
    end else begin
      tag_pipe[0] <= '{valid: ev, last: ev_last};
      for (int i = 1; i <= LV; i++) begin
        tag_pipe[i] <= tag_pipe[i - 1];
      end
    end
  end

  // Round half toward plus infinity, then saturate to 16 bits.
  logic signed [SW:0]   rnd;
  logic signed [YW-1:0] y;
  logic                 ovf;
  rsp_t                 wr_data;
  rsp_t                 rd_data;

  assign rnd = {acc[SW-1], acc} + (SW + 1)'(32768);
  assign y   = YW'(rnd >>> 16);
  assign ovf = !((&y[YW-1:SAMPLE_W-1]) || !(|y[YW-1:SAMPLE_W-1]));

  always_comb begin
    wr_data.clipped     = ovf;
    wr_data.last_output = tag_pipe[LV].last;
    if (!ovf) begin
      wr_data.filtered = y[SAMPLE_W-1:0];
    end else if (y[YW-1]) begin
      wr_data.filtered = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      wr_data.filtered = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
  end

  fce_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (tag_pipe[LV].valid),
    .wr_data  (wr_data),
    .rd_valid (rsp_valid),
    .rd_stall (rsp_stall),
    .rd_data  (rd_data)
  );

  assign filtered    = rd_data.filtered;
  assign clipped     = rd_data.clipped;
  assign last_output = rd_data.last_output;

endmodule

`default_nettype wire

// File: hdl/fce_cell.sv
// ----------------------------------------------------------------------------
// fce_cell
// One tap of the FIR chain: delay register, coefficient and registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fce_cell (
  input  logic               clk,
  input  logic               rst,
  input  fce_pkg::cell_ctl_t ctl,
  input  fce_pkg::sample_t   tap_in,
  input  logic               coef_we,
  input  fce_pkg::coef_t     coef_in,
  input  logic               active,
  output fce_pkg::sample_t   tap,
  output fce_pkg::prod_t     prod
);
  import fce_pkg::*;

  coef_t   coef;
  sample_t tap_mul;
  sample_t tap_next;

  // The product always sees the shifted value, even when the line is cleared.
  assign tap_mul  = ctl.shift ? tap_in : tap;
  assign tap_next = ctl.clear ? '0 : tap_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap  <= '0;
      coef <= '0;
    end else begin
      tap <= tap_next;
      if (coef_we) begin
        coef <= coef_in;
      end
    end
  end

  // Both arms are signed so that the multiply keeps its signed operands.
  always_ff @(posedge clk) begin
    prod <= active ? (tap_mul * coef) : prod_t'(0);
  end

endmodule

`default_nettype wire

// File: hdl/fce_adder_tree.sv
// ----------------------------------------------------------------------------
// fce_adder_tree
// Registered binary tree that sums the products of all cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fce_adder_tree #(
  parameter int N  = 31,
  parameter int SW = fce_pkg::PROD_W + $clog2(N)
) (
  input  logic                 clk,
  input  fce_pkg::prod_t       prod [N],
  output logic signed [SW-1:0] sum
);
  import fce_pkg::*;

  localparam int LV    = $clog2(N);
  localparam int P     = 1 << LV;
  localparam int NODES = 2 * P - 1;

  // Heap order: node j has children 2j+1 and 2j+2, leaves sit at the bottom.
  logic signed [SW-1:0] node [NODES];

  for (genvar j = 0; j < NODES; j++) begin : g_node
    if (j >= P - 1) begin : g_leaf
      if (j - (P - 1) < N) begin : g_used
        assign node[j] = SW'(prod[j - (P - 1)]);
      end else begin : g_pad
        assign node[j] = '0;
      end
    end else begin : g_add
      always_ff @(posedge clk) begin
        node[j] <= node[2 * j + 1] + node[2 * j + 2];
      end
    end
  end

  assign sum = node[0];

endmodule

`default_nettype wire

// File: hdl/fce_fifo.sv
// ----------------------------------------------------------------------------
// fce_fifo
// Result queue between the free-running pipeline and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fce_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  fce_pkg::rsp_t wr_data,
  output logic          rd_valid,
  input  logic          rd_stall,
  output fce_pkg::rsp_t rd_data
);
  import fce_pkg::*;

  rsp_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               rd_en;

  assign rd_valid = (count != '0);
  assign rd_en    = rd_valid && !rd_stall;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW + 1)'(wr_en) - (FIFO_AW + 1)'(rd_en);
    end
  end

endmodule

`default_nettype wire

// File: hdl/fce_checker.sv
// ----------------------------------------------------------------------------
// fce_checker
// Port-level checks of the result channel of the FIR convolution block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fir_convolution_envelope_assert.svh"

module fce_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                rsp_valid,
  input logic                                rsp_stall,
  input logic signed [fce_pkg::SAMPLE_W-1:0] filtered,
  input logic                                clipped,
  input logic                                last_output
);
  import fce_pkg::*;

  // A stalled result holds its place and its value.
  `FCE_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(filtered) && $stable(clipped) && $stable(last_output), "stalled result changed")

  // Reset empties the result queue.
  `FCE_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !rsp_valid, "result shown right after reset")

  // A saturated result sits at one of the two rails.
  `FCE_ASSERT_IMPLY(a_clip_rail, clk, rst, rsp_valid && clipped, (filtered == 16'sh7fff) || (filtered == -16'sh8000), "clipped result not at a rail")

endmodule

bind fir_convolution_envelope fce_checker u_fce_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .filtered    (filtered),
  .clipped     (clipped),
  .last_output (last_output)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIR convolution envelope block.
// A scoreboard class keeps its own copy of the kernel, the delay line and the
// two registers, and predicts every output item of each accepted request.
// Directed requests cover the field extremes and the corner cases. Random
// phases then change the settings and send kernel loads and signals with
// random content. Both channels idle and stall at random, and two long
// receiver hold-offs fill the result queue.
// ----------------------------------------------------------------------------

module tb_top;
  import fce_pkg::*;

  localparam int TAPS         = 31;
  // The drain pause adds margin.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 410;
  localparam int HOLD_CYCLES  = 300;

  // One request item as the sender sees it. Fields that the request type does
  // not use are still filled with random values.
  typedef struct {
    logic    kind;
    logic [IDX_W-1:0] slot;
    coef_t   coef;
    sample_t smp;
    logic    last;
  } req_item_t;

  // --------------------------------------------------------------------------
  // Scoreboard: kernel and delay-line mirror plus the queue of output items
  // that are predicted but not yet seen.
  // --------------------------------------------------------------------------
  class conv_scoreboard;
    rsp_t        pending_outputs[$];
    longint      taps_line[TAPS];
    longint      kernel[TAPS];
    bit          envelope_on;
    int unsigned taps_reg;
    int          errors;
    int          outputs_checked;
    int          clipped_seen;
    int          loads;
    int          samples;
    int          flushes;

    function new();
      foreach (taps_line[k]) begin
        taps_line[k] = 0;
        kernel[k]    = 0;
      end
      envelope_on = 1'b0;
      taps_reg    = 31;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ENVELOPE_MODE) begin
        envelope_on = data[0];
      end else if (idx == REG_ACTIVE_TAPS) begin
        taps_reg = 32'(data[TAPCFG_W-1:0]);
      end
    endfunction

    function int unsigned taps_in_use();
      if (taps_reg < 1) return 1;
      if (taps_reg > TAPS) return TAPS;
      return taps_reg;
    endfunction

    function int outstanding();
      return pending_outputs.size();
    endfunction

    function void shift_in(longint v);
      for (int k = TAPS - 1; k > 0; k--) taps_line[k] = taps_line[k - 1];
      taps_line[0] = v;
    endfunction

    // Exact sum of Q3.31 products, rounded half up to Q1.15, then saturated.
    function void predict_output(int unsigned n, bit last);
      longint acc;
      longint y;
      rsp_t   r;
      acc = 0;
      for (int unsigned k = 0; k < n; k++) acc += taps_line[k] * kernel[k];
      y = (acc + 32768) >>> 16;
      r.clipped = 1'b0;
      if (y > 32767) begin
        y = 32767;
        r.clipped = 1'b1;
      end
      if (y < -32768) begin
        y = -32768;
        r.clipped = 1'b1;
      end
      r.filtered    = sample_t'(y);
      r.last_output = last;
      pending_outputs.push_back(r);
    endfunction

    function void take_request(req_item_t it);
      int unsigned n;
      longint      s;
      n = taps_in_use();
      if (it.kind == REQ_LOAD) begin
        if (it.slot < TAPS) begin
          kernel[it.slot] = it.coef;
          loads++;
        end
        return;
      end
      samples++;
      s = it.smp;
      if (envelope_on) begin
        if (s < 0) s = -s;
        if (s > 32767) s = 32767;
      end
      shift_in(s);
      predict_output(n, it.last && n == 1);
      if (it.last) begin
        flushes++;
        for (int unsigned t = 1; t < n; t++) begin
          shift_in(0);
          predict_output(n, t == n - 1);
        end
        foreach (taps_line[k]) taps_line[k] = 0;
      end
    endfunction

    function void compare_output(sample_t f, logic c, logic l);
      rsp_t e;
      outputs_checked++;
      if (pending_outputs.size() == 0) begin
        $error("output item with nothing predicted: filtered %0d", $signed(f));
        errors++;
        return;
      end
      e = pending_outputs.pop_front();
      if (e.clipped) clipped_seen++;
      if (f !== e.filtered) begin
        $error("filtered: expected %0d, got %0d", $signed(e.filtered), $signed(f));
        errors++;
      end
      if (c !== e.clipped) begin
        $error("clipped: expected %0b, got %0b", e.clipped, c);
        errors++;
      end
      if (l !== e.last_output) begin
        $error("last_output: expected %0b, got %0b", e.last_output, l);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block. Every input starts at a
  // known value.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  req_valid   = 1'b0;
  logic                  req_stall;
  logic                  req_type    = REQ_LOAD;
  logic [IDX_W-1:0]      coef_index  = '0;
  coef_t                 coef_value  = '0;
  sample_t               sample      = '0;
  logic                  last_sample = 1'b0;
  logic                  rsp_valid;
  logic                  rsp_stall   = 1'b0;
  sample_t               filtered;
  logic                  clipped;
  logic                  last_output;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fir_convolution_envelope #(.TAPS(TAPS)) uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .sample     (sample),
    .last_sample(last_sample),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .filtered   (filtered),
    .clipped    (clipped),
    .last_output(last_output),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  conv_scoreboard sb;

  // Bench state shared by the stimulus and the receiver.
  int burst_left    = 0;
  bit no_gaps       = 1'b0;
  int random_sent   = 0;
  int reg_writes    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int rx_cycle      = 0;
  int rx_mode       = 0;

  // --------------------------------------------------------------------------
  // Receiver. Outputs are read at the rising edge, before any nonblocking
  // update of that edge lands, so the bench sees exactly what the block saw.
  // The stall pattern picks from four modes at random. When the stimulus asks
  // for it, a long hold-off keeps rsp_stall high while requests keep coming.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      sb.compare_output(filtered, clipped, last_output);
    end
  end

  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(0, 3) == 0);
        2:       rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= (rx_cycle % 4 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Field generators. Extreme values appear often enough to be hit in every
  // phase; small values keep many sums clear of saturation.
  // --------------------------------------------------------------------------
  function automatic coef_t rand_coef();
    case ($urandom_range(0, 7))
      0:       return coef_t'(-131072);
      1:       return coef_t'(131071);
      2:       return coef_t'(65536);
      3, 4:    return coef_t'(int'($urandom_range(0, 16383)) - 8192);
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_smp();
    case ($urandom_range(0, 7))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return sample_t'(0);
      3, 4:    return sample_t'(int'($urandom_range(0, 2047)) - 1024);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic req_item_t load_item(logic [IDX_W-1:0] slot, coef_t value);
    req_item_t it;
    it.kind = REQ_LOAD;
    it.slot = slot;
    it.coef = value;
    it.smp  = sample_t'($urandom);
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic req_item_t sample_item(sample_t value, logic last);
    req_item_t it;
    it.kind = REQ_SAMPLE;
    it.slot = IDX_W'($urandom_range(0, 31));
    it.coef = coef_t'($urandom);
    it.smp  = value;
    it.last = last;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. The sender works in bursts; between bursts req_valid
  // drops for a random gap unless no_gaps is set. In a burst req_valid stays
  // high from item to item; a stalled item holds its payload until accepted.
  // --------------------------------------------------------------------------
  task automatic send(req_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
      if (no_gaps) gap = 0;
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid   <= 1'b1;
    req_type    <= it.kind;
    coef_index  <= it.slot;
    coef_value  <= it.coef;
    sample      <= it.smp;
    last_sample <= it.last;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.take_request(it);
  endtask

  // Waits until every predicted output item is in, then lets the pipeline
  // run dry, since trailing loads give no output item to wait for.
  task automatic settle();
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write beat. The caller lowers cfg_valid after its last beat.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  // Writes both registers in random order and, now and then, an index that
  // matches no register, which the block must ignore.
  task automatic program_regs(bit env, logic [CFG_DATA_W-1:0] taps_data);
    logic [CFG_DATA_W-1:0] env_data;
    env_data = {7'($urandom_range(0, 127)), env};
    if ($urandom_range(0, 2) == 0) begin
      cfg_write(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
    end
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(REG_ENVELOPE_MODE, env_data);
      cfg_write(REG_ACTIVE_TAPS, taps_data);
    end else begin
      cfg_write(REG_ACTIVE_TAPS, taps_data);
      cfg_write(REG_ENVELOPE_MODE, env_data);
    end
    cfg_valid <= 1'b0;
  endtask

  // One random phase: new settings, usually a fresh kernel, then a signal
  // with random content and random signal ends. A few loads land mid-signal.
  task automatic random_phase(int phase);
    int unsigned taps5;
    int unsigned n;
    int          items;
    int          nload;
    bit          last;
    req_item_t   it;
    settle();
    case ($urandom_range(0, 7))
      0:       taps5 = 0;
      1:       taps5 = 1;
      2:       taps5 = 31;
      3:       taps5 = 2;
      default: taps5 = $urandom_range(1, 31);
    endcase
    program_regs(1'($urandom_range(0, 1)), {3'($urandom_range(0, 7)), 5'(taps5)});
    n = (taps5 == 0) ? 1 : taps5;

    // The long hold-off: the receiver stops while the sender keeps offering
    // items with no gaps, so the queue fills and req_stall has to rise.
    if (phase == 1 || phase == 5) begin
      hold_requests++;
      no_gaps = 1'b1;
    end else begin
      no_gaps = ($urandom_range(0, 3) == 0);
    end

    if ($urandom_range(0, 4) != 0) begin
      nload = $urandom_range(1, n);
      for (int k = 0; k < nload; k++) begin
        send(load_item(IDX_W'(k), rand_coef()));
        random_sent++;
      end
    end

    items = $urandom_range(28, 48);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = load_item(IDX_W'($urandom_range(0, 31)), rand_coef());
        if (it.slot < TAPS) random_sent++;
      end else begin
        last = ($urandom_range(0, 11) == 0) ||
               (i == items - 1 && $urandom_range(0, 3) != 0);
        it = sample_item(rand_smp(), last);
        random_sent++;
      end
      send(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, 31 taps: full-scale coefficients of both signs, a load
    // to the index past the kernel that must be dropped, full-scale samples,
    // and a signal end that flushes the whole tail.
    send(load_item(5'd0, coef_t'(131071)));
    send(load_item(5'd1, coef_t'(-131072)));
    send(load_item(5'd30, coef_t'(131071)));
    send(load_item(5'd31, coef_t'(77777)));
    send(load_item(5'd2, coef_t'(65536)));
    send(sample_item(sample_t'(32767), 1'b0));
    send(sample_item(sample_t'(-32768), 1'b0));
    send(sample_item(sample_t'(0), 1'b0));
    send(sample_item(sample_t'(1), 1'b1));
    settle();

    // Envelope mode with a single tap: the most negative sample rectifies to
    // full scale, and a signal end marks its own output item with no tail.
    program_regs(1'b1, 8'd1);
    send(sample_item(sample_t'(-32768), 1'b0));
    send(sample_item(sample_t'(32767), 1'b1));
    send(load_item(5'd0, coef_t'(-131072)));
    send(sample_item(sample_t'(-1), 1'b0));
    send(sample_item(sample_t'(-32768), 1'b1));
    settle();

    // A tap count of zero with the upper data bits set behaves as one tap.
    program_regs(1'b0, 8'hE0);
    send(sample_item(sample_t'(-32768), 1'b1));
    send(sample_item(sample_t'(100), 1'b0));
    settle();

    // Two taps: unity coefficient in the second slot and a short tail.
    program_regs(1'b1, 8'd2);
    send(load_item(5'd1, coef_t'(65536)));
    send(sample_item(sample_t'(-5), 1'b1));
    send(sample_item(sample_t'(-32768), 1'b1));

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      random_phase(phase);
      phase++;
    end
    settle();

    $display("Run covered %0d kernel loads and %0d samples with %0d signal ends, %0d register writes.",
             sb.loads, sb.samples, sb.flushes, reg_writes);
    $display("Checked %0d output items, %0d of them saturated.",
             sb.outputs_checked, sb.clipped_seen);
    if (sb.errors == 0) begin
      $display("fir_convolution_envelope: match");
    end else begin
      $display("fir_convolution_envelope: mismatch");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #5000000;
    $display("fir_convolution_envelope: mismatch");
    $finish;
  end

endmodule
